@@ rtl/cmt_pkg.sv @@
// shared types and constants for the convex polygon triangulation block
package cmt_pkg;

    localparam int COORD_W  = 16;
    localparam int COST_W   = 40;
    localparam int STAT_W   = 3;
    localparam int FRAC_W   = 8;
    localparam int SQ_W     = 34;
    localparam int RAD_W    = SQ_W + 2 * FRAC_W;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int SUM_W    = 64;
    localparam int MIN_VERTS = 4;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FEW     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_CONCAVE = 3'd2;
    localparam logic [STAT_W-1:0] STAT_ORIENT  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_OVF     = 3'd4;

    localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

    typedef struct packed {
        logic              valid;
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } t_sqrt_stage;

endpackage

@@ rtl/cmt_sqrt_cell.sv @@
// one digit step of the square root chain
module cmt_sqrt_cell
    import cmt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sqrt_stage i_stage,
    output t_sqrt_stage o_stage
);

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    t_sqrt_stage      r_stage;

    assign rem_sh = {i_stage.rem[REM_W-3:0], i_stage.rad[RAD_W-1 -: 2]};
    assign trial  = {1'b0, i_stage.root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= i_stage.valid;
        end
        r_stage.rad <= {i_stage.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            r_stage.rem  <= rem_sh - trial;
            r_stage.root <= {i_stage.root[ROOT_W-2:0], 1'b1};
        end else begin
            r_stage.rem  <= rem_sh;
            r_stage.root <= {i_stage.root[ROOT_W-2:0], 1'b0};
        end
    end

    assign o_stage = r_stage;

endmodule

@@ rtl/cmt_sqrt_chain.sv @@
// row of square root cells, one result bit per cell
module cmt_sqrt_chain
    import cmt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root
);

    t_sqrt_stage stage [ROOT_W+1];

    assign stage[0] = '{valid: i_valid, rad: i_rad, root: '0, rem: '0};

    for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
        cmt_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (stage[g]),
            .o_stage (stage[g+1])
        );
    end

    assign o_valid = stage[ROOT_W].valid;
    assign o_root  = stage[ROOT_W].root;

endmodule

@@ rtl/convex_polygon_min_triangulation.sv @@
// top level: vertex load, polygon check and triangulation sequencer
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | i_in_valid o_in_ready i_vertex_x i_vertex_y     | item in
//          | i_last_vertex                                  |
//  out     | o_out_valid i_out_ready o_total_cost o_status  | item out
//
// vertices load at one item per cycle; after the last one the polygon check
// runs states CHK_A to CHK_E per vertex, then each split of the interval
// program runs K0 to K3, the square root cell chain once for each of the two
// side lengths, then K_SUM and K_CMP, plus a write state per sub-polygon
// reset is synchronous and active low and needs no clearing pass
// input is held off from the last vertex until the result enters the output
// register; a result waits there without stalling the next polygon's load
module convex_polygon_min_triangulation
    import cmt_pkg::*;
#(
    parameter int MAX_VERTICES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COORD_W-1:0] i_vertex_x,
    input  logic [COORD_W-1:0] i_vertex_y,
    input  logic               i_last_vertex,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COST_W-1:0]  o_total_cost,
    output logic [STAT_W-1:0]  o_status
);

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int TAB_DEPTH = 1 << (2 * IW);

    // sequencer states
    localparam logic [4:0] ST_LOAD  = 5'd0;
    localparam logic [4:0] ST_CHK_A = 5'd1;
    localparam logic [4:0] ST_CHK_B = 5'd2;
    localparam logic [4:0] ST_CHK_C = 5'd3;
    localparam logic [4:0] ST_CHK_D = 5'd4;
    localparam logic [4:0] ST_CHK_M = 5'd5;
    localparam logic [4:0] ST_CHK_E = 5'd6;
    localparam logic [4:0] ST_K0    = 5'd7;
    localparam logic [4:0] ST_K1    = 5'd8;
    localparam logic [4:0] ST_K2    = 5'd9;
    localparam logic [4:0] ST_K3    = 5'd10;
    localparam logic [4:0] ST_D_SQ  = 5'd11;
    localparam logic [4:0] ST_D_FD  = 5'd12;
    localparam logic [4:0] ST_D_WT  = 5'd13;
    localparam logic [4:0] ST_K_SUM = 5'd14;
    localparam logic [4:0] ST_K_CMP = 5'd15;
    localparam logic [4:0] ST_K_WR  = 5'd16;
    localparam logic [4:0] ST_DONE  = 5'd17;

    logic [4:0] r_state;

    // vertex store
    logic [COORD_W-1:0] r_mem_x [MAX_VERTICES];
    logic [COORD_W-1:0] r_mem_y [MAX_VERTICES];
    logic [COORD_W-1:0] r_vrd_x, r_vrd_y;
    logic [IW-1:0]      v_raddr;

    // subpolygon cost table, row = size-4, column = start vertex
    logic [COST_W-1:0] r_tab [TAB_DEPTH];
    logic [COST_W-1:0] r_trd;
    logic [2*IW-1:0]   t_raddr;
    logic [2*IW-1:0]   t_waddr;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_s;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_k;

    // check datapath
    logic [COORD_W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [2*COORD_W+1:0] r_p1, r_p2, r_p3;
    logic signed [SUM_W-1:0]     r_sum;
    logic                        r_nconv;

    // dp datapath
    logic [COORD_W-1:0] r_pix, r_piy, r_pxx, r_pxy, r_pex, r_pey;
    logic [COST_W-1:0]  r_c1, r_c2, r_best, r_cost, r_res;
    logic [SQ_W-1:0]    r_mx, r_my;
    logic [ROOT_W-1:0]  r_d1, r_d2;
    logic               r_phase;
    logic [STAT_W-1:0]  r_stat;

    logic              r_out_valid;
    logic [COST_W-1:0] r_out_cost;
    logic [STAT_W-1:0] r_out_stat;

    logic              in_acc;
    logic              cnt_full;
    logic [CW-1:0]     n_cnt;
    logic [CW-1:0]     i1, i2;
    logic [CW:0]       x_sum, e_sum;
    logic [CW-1:0]     x_idx, e_idx;
    logic [CW-1:0]     s_m_k;
    logic              last_split;

    logic              sq_valid;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;

    logic signed [COORD_W:0]     dxa, dya;
    logic signed [2*COORD_W+2:0] turn;
    logic signed [SUM_W-1:0]     sum_n;
    logic                        nconv_n;

    logic [COST_W:0]   c12;
    logic [COST_W-1:0] c12s;
    logic [ROOT_W-1:0] d1m, d2m;
    logic [ROOT_W:0]   dd;
    logic [COST_W:0]   tot;

    assign o_in_ready = (r_state == ST_LOAD);
    assign in_acc     = i_in_valid && o_in_ready;
    assign cnt_full   = (r_count == CW'(MAX_VERTICES));
    assign n_cnt      = cnt_full ? r_count : r_count + 1'b1;

    // cyclic neighbor indexes
    assign i1 = (CW'(r_i) + 1'b1 == r_n) ? '0 : CW'(r_i) + 1'b1;
    assign i2 = (i1 + 1'b1 == r_n) ? '0 : i1 + 1'b1;

    assign x_sum = (CW+1)'(r_i) + (CW+1)'(r_k);
    assign x_idx = (x_sum >= {1'b0, r_n}) ? CW'(x_sum - {1'b0, r_n}) : CW'(x_sum);
    assign e_sum = {1'b0, r_s} + (CW+1)'(r_i) - 1'b1;
    assign e_idx = (e_sum >= {1'b0, r_n}) ? CW'(e_sum - {1'b0, r_n}) : CW'(e_sum);
    assign s_m_k = r_s - CW'(r_k);
    assign last_split = (CW'(r_k) == r_s - 2'd2);

    always_comb begin
        case (r_state)
            ST_CHK_B: v_raddr = IW'(i1);
            ST_CHK_C: v_raddr = IW'(i2);
            ST_K1:    v_raddr = IW'(x_idx);
            ST_K2:    v_raddr = IW'(e_idx);
            default:  v_raddr = r_i;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_K1:   t_raddr = {IW'(s_m_k - 3'd4), IW'(x_idx)};
            default: t_raddr = {r_k - IW'(3), r_i};
        endcase
    end

    assign t_waddr = {IW'(r_s - 3'd4), r_i};

    always_ff @(posedge i_clk) begin
        if (in_acc && !cnt_full) begin
            r_mem_x[IW'(r_count)] <= i_vertex_x;
            r_mem_y[IW'(r_count)] <= i_vertex_y;
        end
        r_vrd_x <= r_mem_x[v_raddr];
        r_vrd_y <= r_mem_y[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_K_WR) begin
            r_tab[t_waddr] <= r_best;
        end
        r_trd <= r_tab[t_raddr];
    end

    // polygon check arithmetic
    assign turn    = (2*COORD_W+3)'(r_p1) - (2*COORD_W+3)'(r_p2);
    assign nconv_n = r_nconv | (turn > 0);
    assign sum_n   = r_sum + SUM_W'(r_p3);

    // side lengths: first from start to split vertex, then split to end
    assign dxa = r_phase ? ($signed({r_pxx[COORD_W-1], r_pxx}) - $signed({r_pex[COORD_W-1], r_pex}))
                         : ($signed({r_pix[COORD_W-1], r_pix}) - $signed({r_pxx[COORD_W-1], r_pxx}));
    assign dya = r_phase ? ($signed({r_pxy[COORD_W-1], r_pxy}) - $signed({r_pey[COORD_W-1], r_pey}))
                         : ($signed({r_piy[COORD_W-1], r_piy}) - $signed({r_pxy[COORD_W-1], r_pxy}));

    // saturating split cost
    assign c12  = {1'b0, r_c1} + {1'b0, r_c2};
    assign c12s = c12[COST_W] ? COST_SAT : c12[COST_W-1:0];
    assign d1m  = (r_k != IW'(1)) ? r_d1 : '0;
    assign d2m  = last_split ? '0 : r_d2;
    assign dd   = {1'b0, d1m} + {1'b0, d2m};
    assign tot  = {1'b0, c12s} + (COST_W+1)'(dd);

    assign sq_valid = (r_state == ST_D_FD);

    cmt_sqrt_chain u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_rad   ({r_mx + r_my, {(2*FRAC_W){1'b0}}}),
        .o_valid (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        if (!cnt_full) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_vertex) begin
                            r_n     <= n_cnt;
                            r_i     <= '0;
                            r_sum   <= '0;
                            r_nconv <= 1'b0;
                            r_res   <= '0;
                            if (r_ovf || cnt_full) begin
                                r_stat  <= STAT_OVF;
                                r_state <= ST_DONE;
                            end else if (n_cnt < CW'(MIN_VERTS)) begin
                                r_stat  <= STAT_FEW;
                                r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_CHK_A;
                            end
                        end
                    end
                end
                ST_CHK_A: r_state <= ST_CHK_B;
                ST_CHK_B: begin
                    r_ax    <= r_vrd_x;
                    r_ay    <= r_vrd_y;
                    r_state <= ST_CHK_C;
                end
                ST_CHK_C: begin
                    r_bx    <= r_vrd_x;
                    r_by    <= r_vrd_y;
                    r_state <= ST_CHK_D;
                end
                ST_CHK_D: begin
                    r_cx    <= r_vrd_x;
                    r_cy    <= r_vrd_y;
                    r_state <= ST_CHK_M;
                end
                ST_CHK_M: begin
                    r_p1 <= ($signed({r_bx[COORD_W-1], r_bx}) - $signed({r_ax[COORD_W-1], r_ax}))
                          * ($signed({r_cy[COORD_W-1], r_cy}) - $signed({r_by[COORD_W-1], r_by}));
                    r_p2 <= ($signed({r_by[COORD_W-1], r_by}) - $signed({r_ay[COORD_W-1], r_ay}))
                          * ($signed({r_cx[COORD_W-1], r_cx}) - $signed({r_bx[COORD_W-1], r_bx}));
                    r_p3 <= ($signed({r_bx[COORD_W-1], r_bx}) - $signed({r_ax[COORD_W-1], r_ax}))
                          * ($signed({r_by[COORD_W-1], r_by}) + $signed({r_ay[COORD_W-1], r_ay}));
                    r_state <= ST_CHK_E;
                end
                ST_CHK_E: begin
                    r_nconv <= nconv_n;
                    r_sum   <= sum_n;
                    if (CW'(r_i) == r_n - 1'b1) begin
                        r_s    <= CW'(MIN_VERTS);
                        r_i    <= '0;
                        r_k    <= IW'(1);
                        r_best <= COST_SAT;
                        if (nconv_n) begin
                            r_stat  <= STAT_CONCAVE;
                            r_state <= ST_DONE;
                        end else if (sum_n <= 0) begin
                            r_stat  <= STAT_ORIENT;
                            r_state <= ST_DONE;
                        end else begin
                            r_stat  <= STAT_OK;
                            r_state <= ST_K0;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_CHK_A;
                    end
                end
                ST_K0: r_state <= ST_K1;
                ST_K1: begin
                    r_c1    <= (r_k >= IW'(3)) ? r_trd : '0;
                    r_pix   <= r_vrd_x;
                    r_piy   <= r_vrd_y;
                    r_state <= ST_K2;
                end
                ST_K2: begin
                    r_c2    <= (s_m_k >= CW'(MIN_VERTS)) ? r_trd : '0;
                    r_pxx   <= r_vrd_x;
                    r_pxy   <= r_vrd_y;
                    r_state <= ST_K3;
                end
                ST_K3: begin
                    r_pex   <= r_vrd_x;
                    r_pey   <= r_vrd_y;
                    r_phase <= 1'b0;
                    r_state <= ST_D_SQ;
                end
                ST_D_SQ: begin
                    r_mx    <= SQ_W'(dxa) * SQ_W'(dxa);
                    r_my    <= SQ_W'(dya) * SQ_W'(dya);
                    r_state <= ST_D_FD;
                end
                ST_D_FD: r_state <= ST_D_WT;
                ST_D_WT: begin
                    if (sq_done) begin
                        if (!r_phase) begin
                            r_d1    <= sq_root;
                            r_phase <= 1'b1;
                            r_state <= ST_D_SQ;
                        end else begin
                            r_d2    <= sq_root;
                            r_state <= ST_K_SUM;
                        end
                    end
                end
                ST_K_SUM: begin
                    r_cost  <= tot[COST_W] ? COST_SAT : tot[COST_W-1:0];
                    r_state <= ST_K_CMP;
                end
                ST_K_CMP: begin
                    // strict compare keeps the earlier split on a tie
                    if (r_cost < r_best) begin
                        r_best <= r_cost;
                    end
                    if (last_split) begin
                        r_state <= ST_K_WR;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_K0;
                    end
                end
                ST_K_WR: begin
                    if (r_s == r_n && r_i == '0) begin
                        r_res <= r_best;
                    end
                    r_k    <= IW'(1);
                    r_best <= COST_SAT;
                    if (CW'(r_i) == r_n - 1'b1) begin
                        r_i <= '0;
                        if (r_s == r_n) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_s     <= r_s + 1'b1;
                            r_state <= ST_K0;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_K0;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= ST_LOAD;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == ST_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_cost <= r_res;
            r_out_stat <= r_stat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_total_cost = r_out_cost;
    assign o_status     = r_out_stat;

endmodule

@@ rtl/cmt_checker.sv @@
// port level checks for the triangulation block, bound to the top level
module cmt_checker
    import cmt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [COORD_W-1:0] i_vertex_x,
    input logic [COORD_W-1:0] i_vertex_y,
    input logic               i_last_vertex,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [COST_W-1:0]  o_total_cost,
    input logic [STAT_W-1:0]  o_status
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_total_cost)
            && $stable(o_status))
        else $error("result changed while stalled");

    // failed polygons report zero cost
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STAT_OK |-> o_total_cost == '0)
        else $error("nonzero cost with error status");

    a_stat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= STAT_OVF)
        else $error("status code out of range");

    // the last vertex closes the input, checked right after it is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_vertex |=> !o_in_ready)
        else $error("input open right after last vertex");

endmodule

bind convex_polygon_min_triangulation cmt_checker u_cmt_checker (.*);

@@ sim/tb_convex_polygon_min_triangulation.sv @@
// self-checking testbench for the convex polygon minimum triangulation block
module tb_convex_polygon_min_triangulation;
    import cmt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 32;
    localparam int STALL_LIMIT = 4000000;
    localparam int ITEM_GOAL = 550;
    localparam longint unsigned COST_ALL = 64'hFF_FFFF_FFFF;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [COORD_W-1:0] i_vertex_x;
    logic [COORD_W-1:0] i_vertex_y;
    logic               i_last_vertex;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [COST_W-1:0]  o_total_cost;
    logic [STAT_W-1:0]  o_status;

    convex_polygon_min_triangulation #(.MAX_VERTICES(CAPACITY)) dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // one expected triangulation result
    typedef struct {
        logic [COST_W-1:0] cost;
        logic [STAT_W-1:0] status;
    } tri_result_t;

    tri_result_t pending_results[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          no_idle = 1'b0;

    // typed expectation riding along with the payload of a directed item
    bit                typed_en = 1'b0;
    logic [COST_W-1:0] typed_cost = '0;
    logic [STAT_W-1:0] typed_status = '0;

    // shadow copy of the polygon held inside the block
    longint            shadow_x [CAPACITY];
    longint            shadow_y [CAPACITY];
    int                shadow_count = 0;
    bit                shadow_ovf = 1'b0;
    longint unsigned   span_cost [CAPACITY][CAPACITY];

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] error: %s", $realtime, what);
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // edge length in q.8, floor of sqrt of the squared length times 2^16
    function automatic longint unsigned edge_len(input int a, input int b);
        longint dx;
        longint dy;
        longint unsigned sq;
        dx = shadow_x[a] - shadow_x[b];
        dy = shadow_y[a] - shadow_y[b];
        sq = longint'(dx * dx) + longint'(dy * dy);
        return int_sqrt(sq << 16);
    endfunction

    function automatic longint unsigned add_sat(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > COST_ALL) ? COST_ALL : s;
    endfunction

    function automatic longint turn_cross(input int a, input int b, input int c);
        return (shadow_x[b] - shadow_x[a]) * (shadow_y[c] - shadow_y[b])
             - (shadow_y[b] - shadow_y[a]) * (shadow_x[c] - shadow_x[b]);
    endfunction

    function automatic logic [STAT_W-1:0] polygon_status(input int n);
        longint area2;
        int     j;
        area2 = 0;
        if (shadow_ovf) return STAT_OVF;
        if (n < MIN_VERTS) return STAT_FEW;
        for (int i = 0; i < n; i++)
            if (turn_cross(i, (i + 1) % n, (i + 2) % n) > 0) return STAT_CONCAVE;
        for (int i = 0; i < n; i++) begin
            j = (i + 1) % n;
            area2 += (shadow_x[j] - shadow_x[i]) * (shadow_y[j] + shadow_y[i]);
        end
        if (!(area2 > 0)) return STAT_ORIENT;
        return STAT_OK;
    endfunction

    // cyclic interval program: span_cost[s-4][i] is the best cost of the
    // sub-polygon of s vertices starting at i
    function automatic longint unsigned min_diag_cost(input int n);
        int              stop;
        int              x;
        longint unsigned best;
        longint unsigned c1;
        longint unsigned c2;
        longint unsigned d1;
        longint unsigned d2;
        for (int s = 4; s <= n; s++) begin
            for (int i = 0; i < n; i++) begin
                stop = (s + i - 1) % n;
                best = COST_ALL;
                for (int k = 1; k <= s - 2; k++) begin
                    x  = (i + k) % n;
                    c1 = (k + 1 >= 4) ? span_cost[k - 3][i] : 0;
                    c2 = (s - k >= 4) ? span_cost[s - k - 4][x] : 0;
                    d1 = (k != 1) ? edge_len(i, x) : 0;
                    d2 = (k != s - 2) ? edge_len(x, stop) : 0;
                    c1 = add_sat(add_sat(c1, c2), add_sat(d1, d2));
                    // ties keep the earlier split
                    if (c1 < best) best = c1;
                end
                span_cost[s - 4][i] = best;
            end
        end
        return span_cost[n - 4][0];
    endfunction

    // advance the shadow state by one vertex item, queue a result on the last
    function automatic void load_vertex(input logic [COORD_W-1:0] vx,
                                        input logic [COORD_W-1:0] vy,
                                        input logic lastv);
        tri_result_t r;
        if (shadow_count < CAPACITY) begin
            shadow_x[shadow_count] = longint'($signed(vx));
            shadow_y[shadow_count] = longint'($signed(vy));
            shadow_count++;
        end else begin
            shadow_ovf = 1'b1;
        end
        if (!lastv) return;
        r.status = polygon_status(shadow_count);
        r.cost   = (r.status == STAT_OK) ? COST_W'(min_diag_cost(shadow_count)) : '0;
        if (typed_en) begin
            r.cost   = typed_cost;
            r.status = typed_status;
        end
        pending_results.push_back(r);
        shadow_count = 0;
        shadow_ovf   = 1'b0;
    endfunction

    // monitor, scoreboard and watchdog, all sampled at the rising edge
    always @(posedge i_clk) begin
        tri_result_t e;
        bit          moved;
        if (i_rst_n) begin
            moved = (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready);
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (i_in_valid && o_in_ready) begin
                load_vertex(i_vertex_x, i_vertex_y, i_last_vertex);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result cost=%0d status=%0d",
                                              o_total_cost, o_status));
                end else begin
                    e = pending_results.pop_front();
                    if (o_status !== e.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, e.status));
                    if (o_total_cost !== e.cost)
                        report_mismatch($sformatf("total_cost %0d, expected %0d",
                                                  o_total_cost, e.cost));
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver: drops ready with roughly 15 percent chance except in quiet stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 15);
        end
    end

    // drive one vertex item and hold it until the block takes it
    task automatic send_vertex(input int vx, input int vy, input bit lastv,
                               input bit typed = 1'b0,
                               input logic [COST_W-1:0] tcost = '0,
                               input logic [STAT_W-1:0] tstat = '0);
        while (!no_idle && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_vertex_x    <= COORD_W'(vx);
        i_vertex_y    <= COORD_W'(vy);
        i_last_vertex <= lastv;
        typed_en      <= typed;
        typed_cost    <= tcost;
        typed_status  <= tstat;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // clockwise polygon on a circle, convex unless rounding bends it
    task automatic send_ring(input int n, input int radius);
        int  cx;
        int  cy;
        real phase;
        real a;
        cx    = $urandom_range(65534 - 2 * radius) - 32767 + radius;
        cy    = $urandom_range(65534 - 2 * radius) - 32767 + radius;
        phase = $urandom_range(6283) / 1000.0;
        for (int k = 0; k < n; k++) begin
            a = phase - 6.283185307 * k / n;
            send_vertex(cx + $rtoi(radius * $cos(a)), cy + $rtoi(radius * $sin(a)),
                        k == n - 1);
        end
    endtask

    task automatic send_noise(input int n);
        for (int k = 0; k < n; k++)
            send_vertex($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                        k == n - 1);
    endtask

    // directed rows, a typed expectation only where it is obvious
    typedef struct {
        int                vx;
        int                vy;
        bit                lastv;
        bit                typed;
        logic [STAT_W-1:0] status;
    } vertex_row_t;

    vertex_row_t directed_rows [] = '{
        // a lone vertex and a triangle are too few
        '{0, 0, 1, 1, STAT_FEW},
        '{-32768, 32767, 0, 0, STAT_OK},
        '{32767, 32767, 0, 0, STAT_OK},
        '{0, -32768, 1, 1, STAT_FEW},
        // clockwise square of side 10
        '{0, 0, 0, 0, STAT_OK},
        '{0, 10, 0, 0, STAT_OK},
        '{10, 10, 0, 0, STAT_OK},
        '{10, 0, 1, 0, STAT_OK},
        // counterclockwise square turns the wrong way at every corner
        '{0, 0, 0, 0, STAT_OK},
        '{10, 0, 0, 0, STAT_OK},
        '{10, 10, 0, 0, STAT_OK},
        '{0, 10, 1, 1, STAT_CONCAVE},
        // dent in the middle makes it concave
        '{0, 0, 0, 0, STAT_OK},
        '{0, 100, 0, 0, STAT_OK},
        '{10, 10, 0, 0, STAT_OK},
        '{100, 0, 1, 1, STAT_CONCAVE},
        // full-range square, corners at the coordinate extremes
        '{-32768, -32768, 0, 0, STAT_OK},
        '{-32768, 32767, 0, 0, STAT_OK},
        '{32767, 32767, 0, 0, STAT_OK},
        '{32767, -32768, 1, 0, STAT_OK},
        // coincident points: no area at all
        '{5, 5, 0, 0, STAT_OK},
        '{5, 5, 0, 0, STAT_OK},
        '{5, 5, 0, 0, STAT_OK},
        '{5, 5, 1, 1, STAT_ORIENT}
    };

    initial begin
        int n;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_vertex_x    = '0;
        i_vertex_y    = '0;
        i_last_vertex = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_vertex(directed_rows[r].vx, directed_rows[r].vy, directed_rows[r].lastv,
                        directed_rows[r].typed, '0, directed_rows[r].status);

        // capacity: one vertex past the store overflows, exactly full does not
        for (int k = 0; k <= CAPACITY; k++)
            send_vertex(k * 100, k * 37, k == CAPACITY, 1'b1, '0, STAT_OVF);
        send_noise(CAPACITY);
        send_ring(16, 30000);

        // hold the sender until everything has drained
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);

        while (items_sent < ITEM_GOAL) begin
            no_idle = (items_sent >= 250 && items_sent < 350);
            n = $urandom_range(99);
            if (n < 70)      send_ring($urandom_range(7, 4), $urandom_range(30000, 8));
            else if (n < 85) send_noise($urandom_range(6, 4));
            else if (n < 95) send_noise($urandom_range(3, 1));
            else             send_ring($urandom_range(10, 8), $urandom_range(30000, 1000));
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;
        @(posedge i_clk);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
